@@ rtl/mfcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Meter frame CRC-16 package
// Shared types, mode codes and CRC helper functions for the frame checker.
// ----------------------------------------------------------------------------
package mfcrc_pkg;

    localparam int unsigned CRC_W   = 16;
    localparam int unsigned CHARS_W = 32;
    localparam int unsigned SNAP_N  = 6;
    localparam int unsigned WIN_N   = 4;

    localparam logic [CRC_W-1:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]       CHAR_BASE = 8'h30;

    localparam logic [2:0] MODE_CHECK_A     = 3'd0;
    localparam logic [2:0] MODE_CHECK_APLUS = 3'd1;
    localparam logic [2:0] MODE_CHECK_B     = 3'd2;
    localparam logic [2:0] MODE_GEN_TAIL5   = 3'd3;
    localparam logic [2:0] MODE_GEN_WHOLE   = 3'd4;

    localparam logic [2:0] COUNT_MAX = 3'd7;

    typedef struct packed {
        logic               too_short;
        logic [CHARS_W-1:0] crc_chars;
        logic [CRC_W-1:0]   crc_value;
        logic               crc_ok;
    } result_t;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] acc_in,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] acc;
        logic [7:0]       d;
        acc = acc_in;
        d   = data;
        for (int k = 0; k < 8; k++) begin
            if (d[7] ^ acc[CRC_W-1]) begin
                acc = {acc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                acc = {acc[CRC_W-2:0], 1'b0};
            end
            d = {d[6:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic logic [CHARS_W-1:0] crc_to_chars(input logic [CRC_W-1:0] v);
        return {CHAR_BASE | {4'h0, v[15:12]}, CHAR_BASE | {4'h0, v[11:8]},
                CHAR_BASE | {4'h0, v[7:4]},   CHAR_BASE | {4'h0, v[3:0]}};
    endfunction

endpackage

@@ rtl/mfcrc_frame.sv @@
// ----------------------------------------------------------------------------
// Meter frame CRC-16 frame engine
// Keeps the running CRC with a short history of earlier values, the last
// trailer bytes and the byte count, and forms the frame result on the last
// byte.
// ----------------------------------------------------------------------------
module mfcrc_frame (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [2:0]           mode,
    input  logic [7:0]           lead_byte,
    output mfcrc_pkg::result_t   result
);

    logic [mfcrc_pkg::CRC_W-1:0] snap_reg [mfcrc_pkg::SNAP_N];
    logic [7:0]                  win_reg  [mfcrc_pkg::WIN_N];
    logic [2:0]                  count_reg;
    logic [2:0]                  frame_mode_reg;

    logic                        first;
    logic [2:0]                  cur_mode;
    logic                        gen;
    logic [7:0]                  byte_in;
    logic [mfcrc_pkg::CRC_W-1:0] crc_next;
    logic [2:0]                  count_next;
    logic [3:0]                  min_len;
    logic [mfcrc_pkg::CRC_W-1:0] crc_sel;
    logic [mfcrc_pkg::CRC_W-1:0] digits;
    logic                        short_f;

    always_comb begin
        first    = (count_reg == 3'd0);
        cur_mode = first ? mode : frame_mode_reg;
        gen      = (cur_mode == mfcrc_pkg::MODE_GEN_TAIL5) ||
                   (cur_mode == mfcrc_pkg::MODE_GEN_WHOLE);
        byte_in  = (first && cur_mode == mfcrc_pkg::MODE_CHECK_APLUS) ? lead_byte : data_byte;
        crc_next = (first && gen) ? snap_reg[0] : mfcrc_pkg::crc_byte(snap_reg[0], byte_in);
        count_next = (count_reg == mfcrc_pkg::COUNT_MAX) ? count_reg : count_reg + 3'd1;

        unique case (cur_mode)
            mfcrc_pkg::MODE_CHECK_A: begin
                min_len = 4'd5;
                crc_sel = snap_reg[3];
            end
            mfcrc_pkg::MODE_CHECK_APLUS: begin
                min_len = 4'd7;
                crc_sel = snap_reg[5];
            end
            mfcrc_pkg::MODE_CHECK_B: begin
                min_len = 4'd6;
                crc_sel = snap_reg[4];
            end
            mfcrc_pkg::MODE_GEN_TAIL5: begin
                min_len = 4'd6;
                crc_sel = snap_reg[4];
            end
            mfcrc_pkg::MODE_GEN_WHOLE: begin
                min_len = 4'd1;
                crc_sel = crc_next;
            end
            default: begin
                min_len = 4'd8;
                crc_sel = '0;
            end
        endcase

        if (cur_mode == mfcrc_pkg::MODE_CHECK_APLUS) begin
            digits = {win_reg[3][3:0], win_reg[2][3:0], win_reg[1][3:0], win_reg[0][3:0]};
        end else begin
            digits = {win_reg[2][3:0], win_reg[1][3:0], win_reg[0][3:0], byte_in[3:0]};
        end

        short_f = ({1'b0, count_next} < min_len);

        result.too_short = short_f;
        result.crc_ok    = !short_f && !gen && (crc_sel == digits);
        result.crc_value = short_f ? '0 : crc_sel;
        result.crc_chars = short_f ? '0 : mfcrc_pkg::crc_to_chars(crc_sel);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            frame_mode_reg <= '0;
            for (int j = 0; j < mfcrc_pkg::SNAP_N; j++) begin
                snap_reg[j] <= '0;
            end
            for (int j = 0; j < mfcrc_pkg::WIN_N; j++) begin
                win_reg[j] <= '0;
            end
        end else if (step_en) begin
            frame_mode_reg <= cur_mode;
            if (last_byte) begin
                count_reg <= '0;
                for (int j = 0; j < mfcrc_pkg::SNAP_N; j++) begin
                    snap_reg[j] <= '0;
                end
                for (int j = 0; j < mfcrc_pkg::WIN_N; j++) begin
                    win_reg[j] <= '0;
                end
            end else begin
                count_reg   <= count_next;
                snap_reg[0] <= crc_next;
                for (int j = 1; j < mfcrc_pkg::SNAP_N; j++) begin
                    snap_reg[j] <= snap_reg[j-1];
                end
                win_reg[0] <= byte_in;
                for (int j = 1; j < mfcrc_pkg::WIN_N; j++) begin
                    win_reg[j] <= win_reg[j-1];
                end
            end
        end
    end

endmodule

@@ rtl/meter_frame_crc16_check_and_gen.sv @@
// ----------------------------------------------------------------------------
// Meter frame CRC-16 check and generate
// Checks or generates the CRC-16 trailer of meter link frames, one result
// transfer per frame.
//
//   Channel  Direction  Carries
//   s_       in         frame byte, end-of-frame mark, mode
//   m_       out        one frame result per frame
//   cfg_     in         lead byte for A-plus frames
//
// One byte is taken every cycle while the input register can advance. Each
// byte waits in the input register and is folded by a single byte-wide CRC
// update; the result of a frame is loaded into the output register at the
// edge where its last byte leaves the input register.
// A stalled result blocks only the next last byte.
// Reset clears all frame state and loads the lead byte with 0x56.
// ----------------------------------------------------------------------------
module meter_frame_crc16_check_and_gen (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [0] crc_ok, [16:1] crc_value, [48:17] crc_chars,
                                   // [49] too_short, [55:50] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic               in_valid_reg;
    logic [7:0]         in_data_reg;
    logic               in_last_reg;
    logic [2:0]         in_mode_reg;
    logic               out_valid_reg;
    logic [55:0]        out_data_reg;
    logic [7:0]         lead_reg;
    logic               advance;
    mfcrc_pkg::result_t result;

    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    mfcrc_frame u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .mode      (in_mode_reg),
        .lead_byte (lead_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lead_reg      <= 8'h56;
        end else begin
            if (cfg_valid && cfg_ready) begin
                lead_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
            in_mode_reg <= s_tuser;
        end
        if (advance && in_last_reg) begin
            out_data_reg <= {6'b0, result.too_short, result.crc_chars,
                             result.crc_value, result.crc_ok};
        end
    end

endmodule
